// File: src/tsts_pkg.sv
// shared types and constants of the thread slot table scheduler
package tsts_pkg;

	localparam int NUM_SLOTS = 64;
	localparam int SLOT_W    = 6;
	localparam int CNT_W     = 7;
	localparam int OWNER_W   = 6;

	// request kinds
	localparam logic [1:0] REQ_CREATE = 2'd0;
	localparam logic [1:0] REQ_KILL   = 2'd1;
	localparam logic [1:0] REQ_SCHED  = 2'd2;
	localparam logic [1:0] REQ_SETRUN = 2'd3;

	// slot states
	localparam logic [1:0] SLOT_FREE  = 2'd0;
	localparam logic [1:0] SLOT_ALLOC = 2'd1;
	localparam logic [1:0] SLOT_RUN   = 2'd2;
	localparam logic [1:0] SLOT_ENDED = 2'd3;

	// result status codes
	localparam logic [2:0] STAT_OK    = 3'd0;
	localparam logic [2:0] STAT_NONE  = 3'd1;
	localparam logic [2:0] STAT_KFREE = 3'd2;
	localparam logic [2:0] STAT_ENDED = 3'd3;
	localparam logic [2:0] STAT_FULL  = 3'd4;

	typedef struct packed {
		logic [1:0]         st;
		logic [OWNER_W-1:0] owner;
	} slot_ent_t;

endpackage

// File: src/thread_slot_table_scheduler.sv
// top level of the thread slot table scheduler
//
// One request enters on the s_ group, one result leaves on the m_ group.
// A transfer happens when tvalid and tready are both high at a clock edge.
// s_tready is high only while the sequencer is idle; one request is in work
// at a time. The slot table (state and owner) and the ended list each live
// in a synchronous ram with registered read data.
// Steps per request:
//   set process bit: write the bit, then result
//   kill: slot read, evaluate, result
//   schedule: one slot per cycle through the scan, then result
//   create: a read and a clear per entry on the ended list for cleanup,
//   then the same scan as schedule
// The cleanup and the scan of the slot ram set the worst case.
// Reset clears all control state; the slot table reads as all free through
// per-slot valid bits, so no clearing pass is needed.
// When m_tready is low, the result holds in the output register; a new
// request is still taken, and its result waits until the register frees.
module thread_slot_table_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // slot_id[5:0], owner_id[11:6], setup_ok[12], proc_run_value[13]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // status[2:0], slot_out[8:3], live_count[15:9]
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CLN  = 3'd1;
	localparam logic [2:0] S_CLNW = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_KRD  = 3'd4;
	localparam logic [2:0] S_KEV  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	localparam int SW = tsts_pkg::SLOT_W;
	localparam int CW = tsts_pkg::CNT_W;
	localparam int OW = tsts_pkg::OWNER_W;
	localparam logic [CW-1:0] NSLOT = CW'(tsts_pkg::NUM_SLOTS);

	logic [2:0]    state_q;
	logic [1:0]    req_q;
	logic [SW-1:0] sid_q;
	logic [OW-1:0] own_q;
	logic          ok_q;

	logic [CW-1:0] ecnt_q;
	logic [SW-1:0] hint_q;
	logic [SW-1:0] last_q;
	logic [CW-1:0] live_q;
	logic [tsts_pkg::NUM_SLOTS-1:0] valid_q;
	logic [tsts_pkg::NUM_SLOTS-1:0] prun_q;

	logic [SW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic          p_s1;
	logic [SW-1:0] addr_s1;

	logic [2:0]    rstat_q;
	logic [SW-1:0] rslot_q;
	logic          m_valid_q;
	logic [15:0]   m_data_q;

	logic                slot_we;
	logic [SW-1:0]       slot_waddr;
	tsts_pkg::slot_ent_t slot_wdata;
	logic [SW-1:0]       slot_raddr;
	tsts_pkg::slot_ent_t slot_rdata;
	tsts_pkg::slot_ent_t eff;

	logic          end_we;
	logic [SW-1:0] end_raddr;
	logic [SW-1:0] end_rdata;

	logic hit;
	logic out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign out_free = !m_valid_q || m_tready;

	// slot table and ended list
	tsts_ram #(.WIDTH(2 + OW), .DEPTH(tsts_pkg::NUM_SLOTS)) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_waddr),
		.wdata(slot_wdata),
		.raddr(slot_raddr),
		.rdata(slot_rdata)
	);

	tsts_ram #(.WIDTH(SW), .DEPTH(tsts_pkg::NUM_SLOTS)) u_end_ram (
		.clk  (clk),
		.we   (end_we),
		.waddr(ecnt_q[SW-1:0]),
		.wdata(sid_q),
		.raddr(end_raddr),
		.rdata(end_rdata)
	);

	// entry as seen through the valid bits
	assign eff = valid_q[addr_s1] ? slot_rdata : '0;

	// scan match
	always_comb begin
		if (req_q == tsts_pkg::REQ_CREATE) begin
			hit = p_s1 && (eff.st == tsts_pkg::SLOT_FREE);
		end else begin
			hit = p_s1 && (eff.st == tsts_pkg::SLOT_RUN) && prun_q[eff.owner];
		end
	end

	// ram address and write control
	always_comb begin
		slot_raddr = (state_q == S_KRD) ? sid_q : idx_q;
		end_raddr  = SW'(ecnt_q - CW'(1));
		slot_we    = 1'b0;
		slot_waddr = addr_s1;
		slot_wdata = '0;
		end_we     = 1'b0;
		if (state_q == S_SCAN && hit && req_q == tsts_pkg::REQ_CREATE && ok_q) begin
			slot_we          = 1'b1;
			slot_wdata.st    = tsts_pkg::SLOT_RUN;
			slot_wdata.owner = own_q;
		end
		if (state_q == S_KEV && eff.st != tsts_pkg::SLOT_FREE
			&& eff.st != tsts_pkg::SLOT_ENDED && ecnt_q < NSLOT) begin
			end_we = 1'b1;
			if (eff.st == tsts_pkg::SLOT_RUN) begin
				slot_we          = 1'b1;
				slot_wdata.st    = tsts_pkg::SLOT_ENDED;
				slot_wdata.owner = eff.owner;
			end
		end
	end

	// payload registers of the request
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q <= s_tuser;
			sid_q <= s_tdata[5:0];
			own_q <= s_tdata[11:6];
			ok_q  <= s_tdata[12];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ecnt_q    <= '0;
			hint_q    <= '0;
			last_q    <= SW'(tsts_pkg::NUM_SLOTS - 1);
			live_q    <= '0;
			valid_q   <= '0;
			prun_q    <= '0;
			idx_q     <= '0;
			n_q       <= '0;
			p_s1      <= 1'b0;
			addr_s1   <= '0;
			rstat_q   <= tsts_pkg::STAT_OK;
			rslot_q   <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (m_valid_q && m_tready && state_q != S_FIN) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						n_q  <= '0;
						p_s1 <= 1'b0;
						case (s_tuser)
							tsts_pkg::REQ_CREATE: begin
								idx_q   <= hint_q;
								state_q <= (ecnt_q != '0) ? S_CLN : S_SCAN;
							end
							tsts_pkg::REQ_KILL: begin
								state_q <= S_KRD;
							end
							tsts_pkg::REQ_SCHED: begin
								idx_q   <= last_q + SW'(1);
								state_q <= S_SCAN;
							end
							default: begin
								prun_q[s_tdata[11:6]] <= s_tdata[13];
								rstat_q <= tsts_pkg::STAT_OK;
								rslot_q <= '0;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_CLN: begin
					ecnt_q  <= ecnt_q - CW'(1);
					state_q <= S_CLNW;
				end
				S_CLNW: begin
					valid_q[end_rdata] <= 1'b0;
					state_q <= (ecnt_q != '0) ? S_CLN : S_SCAN;
				end
				S_SCAN: begin
					if (hit) begin
						// evaluate side: slot found
						p_s1    <= 1'b0;
						state_q <= S_FIN;
						if (req_q == tsts_pkg::REQ_CREATE) begin
							hint_q <= addr_s1;
							if (ok_q) begin
								valid_q[addr_s1] <= 1'b1;
								if (live_q < NSLOT) begin
									live_q <= live_q + CW'(1);
								end
								rstat_q <= tsts_pkg::STAT_OK;
								rslot_q <= addr_s1;
							end else begin
								valid_q[addr_s1] <= 1'b0;
								rstat_q <= tsts_pkg::STAT_NONE;
								rslot_q <= '0;
							end
						end else begin
							last_q  <= addr_s1;
							rstat_q <= tsts_pkg::STAT_OK;
							rslot_q <= addr_s1;
						end
					end else if (n_q < NSLOT) begin
						// issue side
						addr_s1 <= idx_q;
						p_s1    <= 1'b1;
						idx_q   <= idx_q + SW'(1);
						n_q     <= n_q + CW'(1);
					end else if (p_s1) begin
						p_s1 <= 1'b0;
					end else begin
						rstat_q <= tsts_pkg::STAT_NONE;
						rslot_q <= '0;
						state_q <= S_FIN;
					end
				end
				S_KRD: begin
					addr_s1 <= sid_q;
					state_q <= S_KEV;
				end
				S_KEV: begin
					rslot_q <= '0;
					state_q <= S_FIN;
					if (eff.st == tsts_pkg::SLOT_FREE) begin
						rstat_q <= tsts_pkg::STAT_KFREE;
					end else if (eff.st == tsts_pkg::SLOT_ENDED) begin
						rstat_q <= tsts_pkg::STAT_ENDED;
					end else if (ecnt_q >= NSLOT) begin
						rstat_q <= tsts_pkg::STAT_FULL;
					end else begin
						rstat_q <= tsts_pkg::STAT_OK;
						ecnt_q  <= ecnt_q + CW'(1);
						if (live_q != '0) begin
							live_q <= live_q - CW'(1);
						end
					end
				end
				S_FIN: begin
					// hand the result to the output register
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {live_q, rslot_q, rstat_q};
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// live counter and ended list never exceed the table size
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= NSLOT) else $error("live counter above slot count");
	a_ecnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ecnt_q <= NSLOT) else $error("ended list count above slot count");
	// a slot is only bound on a create whose setup succeeded
	a_bind_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_we && slot_wdata.st == tsts_pkg::SLOT_RUN)
		|-> (req_q == tsts_pkg::REQ_CREATE && ok_q))
		else $error("slot bound without successful setup");
	// a new result is only loaded when the output register is free
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && m_valid_q && !m_tready) |=> (state_q == S_FIN))
		else $error("result dropped while output stalled");
`endif

endmodule

// File: src/tsts_ram.sv
// generic single-write, single-read ram with registered read data
module tsts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: tb/tb_thread_slot_table_scheduler.sv
// testbench of the thread slot table scheduler: directed table, fill and kill of every slot, then random requests
module tb_thread_slot_table_scheduler;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_ITEMS   = 1600;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;  // slot_id[5:0], owner_id[11:6], setup_ok[12], proc_run_value[13]
	logic [1:0]  s_tuser;  // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // status[2:0], slot_out[8:3], live_count[15:9]

	thread_slot_table_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	typedef struct packed {
		logic [1:0] req;
		logic [5:0] sid;
		logic [5:0] owner;
		logic       ok;
		logic       pval;
	} thr_req_t;

	// packed as on m_tdata, status in the lowest bits
	typedef struct packed {
		logic [6:0] live;
		logic [5:0] slot;
		logic [2:0] status;
	} thr_res_t;

	// directed row: request plus optional typed-in result
	typedef struct packed {
		thr_req_t rq;
		logic     fixed;
		thr_res_t res;
	} dir_row_t;

	// predictor state
	logic [1:0] tbl_state [tsts_pkg::NUM_SLOTS];
	logic [5:0] tbl_owner [tsts_pkg::NUM_SLOTS];
	logic [5:0] end_list  [tsts_pkg::NUM_SLOTS];
	int         end_cnt;
	int         hint;
	int         last_sched;
	int         live;
	logic       proc_on [64];

	thr_res_t result_q [$];
	thr_res_t typed_q [$];
	logic     typed_flag_q [$];
	int       err_count = 0;
	int       idle_cycles = 0;
	bit       quiet = 0;   // no idling stretch

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic thr_res_t predict(thr_req_t r);
		thr_res_t o;
		int i, n;
		bit found;
		logic [1:0] st;
		o = '0;
		found = 0;
		case (r.req)
			tsts_pkg::REQ_CREATE: begin
				// clean the ended list first
				while (end_cnt > 0) begin
					end_cnt--;
					tbl_state[end_list[end_cnt]] = tsts_pkg::SLOT_FREE;
					tbl_owner[end_list[end_cnt]] = '0;
				end
				i = hint;
				for (n = 0; n < tsts_pkg::NUM_SLOTS; n++) begin
					if (tbl_state[i] == tsts_pkg::SLOT_FREE) begin
						found = 1;
						break;
					end
					i = (i + 1) % tsts_pkg::NUM_SLOTS;
				end
				if (!found) o.status = tsts_pkg::STAT_NONE;
				else begin
					hint = i;
					if (!r.ok) begin
						tbl_state[i] = tsts_pkg::SLOT_FREE;
						tbl_owner[i] = '0;
						o.status = tsts_pkg::STAT_NONE;
					end else begin
						tbl_owner[i] = r.owner;
						tbl_state[i] = tsts_pkg::SLOT_RUN;
						if (live < tsts_pkg::NUM_SLOTS) live++;
						o.slot = 6'(i);
					end
				end
			end
			tsts_pkg::REQ_KILL: begin
				st = tbl_state[r.sid];
				if (st == tsts_pkg::SLOT_FREE) o.status = tsts_pkg::STAT_KFREE;
				else if (st == tsts_pkg::SLOT_ENDED) o.status = tsts_pkg::STAT_ENDED;
				else if (end_cnt >= tsts_pkg::NUM_SLOTS) o.status = tsts_pkg::STAT_FULL;
				else begin
					if (st == tsts_pkg::SLOT_RUN) tbl_state[r.sid] = tsts_pkg::SLOT_ENDED;
					end_list[end_cnt] = r.sid;
					end_cnt++;
					if (live > 0) live--;
				end
			end
			tsts_pkg::REQ_SCHED: begin
				i = last_sched;
				for (n = 0; n < tsts_pkg::NUM_SLOTS; n++) begin
					i = (i + 1) % tsts_pkg::NUM_SLOTS;
					if (tbl_state[i] == tsts_pkg::SLOT_RUN && proc_on[tbl_owner[i]]) begin
						found = 1;
						break;
					end
				end
				if (found) begin
					last_sched = i;
					o.slot = 6'(i);
				end else o.status = tsts_pkg::STAT_NONE;
			end
			default: proc_on[r.owner] = r.pval;
		endcase
		o.live = 7'(live);
		return o;
	endfunction

	// drive one request, predict it once accepted
	task automatic send_req(thr_req_t r, bit fixed, thr_res_t res);
		while (!quiet && $urandom_range(99) < 16) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= r.req;
		s_tdata  <= {2'b00, r.pval, r.ok, r.owner, r.sid};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		result_q.push_back(predict(r));
		typed_q.push_back(res);
		typed_flag_q.push_back(fixed);
		@(negedge clk);
	endtask

	function automatic thr_req_t rand_req();
		thr_req_t r;
		int k;
		k = $urandom_range(99);
		r.req   = (k < 30) ? tsts_pkg::REQ_CREATE : (k < 55) ? tsts_pkg::REQ_KILL :
			(k < 80) ? tsts_pkg::REQ_SCHED : tsts_pkg::REQ_SETRUN;
		r.sid   = 6'($urandom_range(63));
		r.owner = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
		r.ok    = ($urandom_range(9) != 0);
		r.pval  = ($urandom_range(3) != 0);
		return r;
	endfunction

	// receiver stall and result check
	always @(negedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= quiet || ($urandom_range(99) >= 16);
	end

	always @(posedge clk) begin
		thr_res_t got, want, typed;
		bit fx;
		if (arst_n && (s_tvalid && s_tready || m_tvalid && m_tready)) idle_cycles <= 0;
		else if (arst_n) idle_cycles <= idle_cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (result_q.size() == 0) begin
				err_count++;
				if (err_count <= 10) $display("unexpected result %h", got);
			end else begin
				want  = result_q.pop_front();
				typed = typed_q.pop_front();
				fx    = typed_flag_q.pop_front();
				if (fx && typed != want) want = typed;
				if (got.status !== want.status || got.slot !== want.slot ||
				    got.live !== want.live) begin
					err_count++;
					if (err_count <= 10)
						$display("mismatch: exp st=%0d slot=%0d live=%0d got st=%0d slot=%0d live=%0d",
							want.status, want.slot, want.live, got.status, got.slot, got.live);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic dir_row_t mk(logic [1:0] q, int s, int o, bit ok, bit pv,
		bit fx, int st, int sl, int lv);
		dir_row_t d;
		d.rq.req = q; d.rq.sid = 6'(s); d.rq.owner = 6'(o); d.rq.ok = ok; d.rq.pval = pv;
		d.fixed = fx; d.res.status = 3'(st); d.res.slot = 6'(sl); d.res.live = 7'(lv);
		return d;
	endfunction

	dir_row_t dir_tab [$];

	initial begin
		thr_req_t r;
		int k, n;
		for (k = 0; k < tsts_pkg::NUM_SLOTS; k++) begin
			tbl_state[k] = tsts_pkg::SLOT_FREE; tbl_owner[k] = '0; end_list[k] = '0;
		end
		for (k = 0; k < 64; k++) proc_on[k] = 1'b0;
		end_cnt = 0; hint = 0; last_sched = tsts_pkg::NUM_SLOTS - 1; live = 0;
		arst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed table: values after reset, extremes and error codes
		dir_tab.push_back(mk(tsts_pkg::REQ_SCHED, 0, 0, 0, 0, 1, tsts_pkg::STAT_NONE, 0, 0));
		dir_tab.push_back(mk(tsts_pkg::REQ_KILL, 63, 0, 0, 0, 1, tsts_pkg::STAT_KFREE, 0, 0));
		dir_tab.push_back(mk(tsts_pkg::REQ_CREATE, 0, 63, 0, 1, 1, tsts_pkg::STAT_NONE, 0, 0));
		dir_tab.push_back(mk(tsts_pkg::REQ_CREATE, 0, 63, 1, 0, 1, tsts_pkg::STAT_OK, 0, 1));
		dir_tab.push_back(mk(tsts_pkg::REQ_SCHED, 0, 0, 0, 0, 1, tsts_pkg::STAT_NONE, 0, 1));
		dir_tab.push_back(mk(tsts_pkg::REQ_SETRUN, 63, 63, 1, 1, 1, tsts_pkg::STAT_OK, 0, 1));
		dir_tab.push_back(mk(tsts_pkg::REQ_SCHED, 0, 0, 0, 0, 1, tsts_pkg::STAT_OK, 0, 1));
		dir_tab.push_back(mk(tsts_pkg::REQ_CREATE, 0, 0, 1, 0, 1, tsts_pkg::STAT_OK, 1, 2));
		dir_tab.push_back(mk(tsts_pkg::REQ_SETRUN, 0, 0, 0, 1, 0, 0, 0, 0));
		dir_tab.push_back(mk(tsts_pkg::REQ_SCHED, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(tsts_pkg::REQ_SCHED, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(tsts_pkg::REQ_KILL, 0, 0, 0, 0, 1, tsts_pkg::STAT_OK, 0, 1));
		dir_tab.push_back(mk(tsts_pkg::REQ_KILL, 0, 0, 0, 0, 1, tsts_pkg::STAT_ENDED, 0, 1));
		dir_tab.push_back(mk(tsts_pkg::REQ_SETRUN, 0, 63, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(tsts_pkg::REQ_SCHED, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(tsts_pkg::REQ_CREATE, 0, 5, 1, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(tsts_pkg::REQ_KILL, 1, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(mk(tsts_pkg::REQ_CREATE, 0, 7, 1, 1, 0, 0, 0, 0));
		foreach (dir_tab[k]) send_req(dir_tab[k].rq, dir_tab[k].fixed, dir_tab[k].res);

		// fill every slot, then kill them all so the ended list fills up
		for (k = 0; k < 66; k++) begin
			r = '0; r.req = tsts_pkg::REQ_CREATE; r.owner = 6'(k); r.ok = 1'b1;
			send_req(r, 0, '0);
		end
		for (k = 0; k < 65; k++) begin
			r = '0; r.req = tsts_pkg::REQ_KILL; r.sid = 6'(k % 64);
			send_req(r, 0, '0);
		end
		r = '0; r.req = tsts_pkg::REQ_SCHED;
		send_req(r, 0, '0);

		// hold off until every result has come back
		s_tvalid <= 1'b0;
		do @(negedge clk); while (result_q.size() != 0);

		// random part, with a stretch without idling
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 600 && n < 800);
			send_req(rand_req(), 0, '0);
		end
		quiet = 0;

		s_tvalid <= 1'b0;
		do @(negedge clk); while (result_q.size() != 0);
		repeat (200) @(negedge clk);
		if (err_count == 0 && result_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
